// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared shorthand for clocked assertions with an active-low reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define C2DT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define C2DT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/c2dt_pkg.sv =====
// ============================================================================
// c2dt_pkg
// Types, sizes and codes shared by the transposed convolution unit.
// ============================================================================
package c2dt_pkg;

    // Sizing.
    localparam int MAX_SIDE   = 64;
    localparam int MAX_RADIUS = 3;
    localparam int PIXEL_BITS = 16;
    localparam int COEF_BITS  = 16;

    localparam int KSIDE     = 2 * MAX_RADIUS + 1;
    localparam int KDEPTH    = KSIDE * KSIDE;
    localparam int IMG_DEPTH = MAX_SIDE * MAX_SIDE;

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SIZE_W = IDX_W + 1;
    localparam int IMG_AW = 2 * IDX_W;
    localparam int KIDX_W = $clog2(KSIDE);
    localparam int KAW    = $clog2(KDEPTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int POS_W  = ((IDX_W > KIDX_W) ? IDX_W : KIDX_W) + 2;
    localparam int PROD_W = PIXEL_BITS + COEF_BITS;

    // Fixed field widths.
    localparam int RESP_W  = 37;
    localparam int CFG_W   = 7;
    localparam int CFG_AW  = 2;
    localparam int VALUE_W = 16;

    // Function codes.
    localparam logic [1:0] FUNC_LOAD_KERNEL = 2'd0;
    localparam logic [1:0] FUNC_LOAD_IMAGE  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

    // Register indexes.
    localparam logic [CFG_AW-1:0] CFG_IMAGE_ROWS    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_COLS    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_KERNEL_RADIUS = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic [5:0]                row;
        logic [5:0]                col;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [RESP_W-1:0] response;
        logic                     bad_size;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/c2dt_ram.sv =====
// ============================================================================
// c2dt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module c2dt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/conv2d_transpose_symmetric_border_unit.sv =====
// ============================================================================
// conv2d_transpose_symmetric_border_unit
// Transposed 2-D convolution of a stored image with half-sample reflection.
// ============================================================================
// Usage. The input channel (in_valid, in_stall, in_data) carries three kinds
// of transaction: a kernel coefficient load, an image pixel load and a
// compute request. Loads write straight into the kernel or image RAM at the
// accepting edge, produce no result and leave the unit ready in the next
// cycle. A compute request produces exactly one result transaction on the
// output channel (out_valid, out_stall, out_data).
// Timing. A compute request walks all (2R+1)^2 kernel taps, one image RAM
// and one kernel RAM read per cycle feeding a single multiply-accumulate
// pipeline. Once the pipeline drains, the result enters the output register
// as soon as that register is free. A request for an undersized image or
// for a pixel outside the image walks no taps, and its result enters the
// output register as soon as that register is free. in_stall stays high
// while a request is in flight. The result sits in an output register. A
// new transaction is taken while a stalled result waits; only a second
// compute result waits for the register.
// Reset returns the sizes to 64 x 64 with R = 1 and empties the output
// register. RAM contents are not cleared and are undefined until written.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user writes it only while no request is in flight, as the unit does not enforce it.
// ============================================================================
module conv2d_transpose_symmetric_border_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  c2dt_pkg::in_item_t                       in_data,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output c2dt_pkg::out_item_t                      out_data,
    input  logic                                     cfg_write,
    input  logic [c2dt_pkg::CFG_AW-1:0]              cfg_index,
    input  logic [c2dt_pkg::CFG_W-1:0]               cfg_data
);

    // Configuration registers.
    logic [c2dt_pkg::CFG_W-1:0] rows_cfg_reg;
    logic [c2dt_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [1:0]                 radius_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg   <= c2dt_pkg::CFG_W'(64);
            cols_cfg_reg   <= c2dt_pkg::CFG_W'(64);
            radius_cfg_reg <= 2'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                c2dt_pkg::CFG_IMAGE_ROWS:    rows_cfg_reg   <= cfg_data;
                c2dt_pkg::CFG_IMAGE_COLS:    cols_cfg_reg   <= cfg_data;
                c2dt_pkg::CFG_KERNEL_RADIUS: radius_cfg_reg <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

    // Effective sizes: oversized settings act as the largest supported size.
    logic [c2dt_pkg::SIZE_W-1:0] nr_c;
    logic [c2dt_pkg::SIZE_W-1:0] nc_c;
    logic [c2dt_pkg::RAD_W-1:0]  rad_c;

    assign nr_c = (int'(rows_cfg_reg) > c2dt_pkg::MAX_SIDE) ?
                  c2dt_pkg::SIZE_W'(c2dt_pkg::MAX_SIDE) : c2dt_pkg::SIZE_W'(rows_cfg_reg);
    assign nc_c = (int'(cols_cfg_reg) > c2dt_pkg::MAX_SIDE) ?
                  c2dt_pkg::SIZE_W'(c2dt_pkg::MAX_SIDE) : c2dt_pkg::SIZE_W'(cols_cfg_reg);
    assign rad_c = (int'(radius_cfg_reg) > c2dt_pkg::MAX_RADIUS) ?
                   c2dt_pkg::RAD_W'(c2dt_pkg::MAX_RADIUS) : c2dt_pkg::RAD_W'(radius_cfg_reg);

    // Input decode.
    logic in_fire;
    logic is_kload;
    logic is_iload;
    logic is_compute;
    logic size_bad;
    logic outside;

    assign in_fire    = in_valid && !in_stall;
    assign is_kload   = in_data.func == c2dt_pkg::FUNC_LOAD_KERNEL;
    assign is_iload   = in_data.func == c2dt_pkg::FUNC_LOAD_IMAGE;
    assign is_compute = in_data.func == c2dt_pkg::FUNC_COMPUTE;
    // The image is too small when either side is at most 2R.
    assign size_bad   = (int'(nr_c) <= 2 * int'(rad_c)) || (int'(nc_c) <= 2 * int'(rad_c));
    assign outside    = (int'(in_data.row) >= int'(nr_c)) || (int'(in_data.col) >= int'(nc_c));

    // Write ports of the two stores. Loads outside the valid range are dropped.
    logic                           kern_we;
    logic [c2dt_pkg::KAW-1:0]       kern_waddr;
    logic [c2dt_pkg::COEF_BITS-1:0] kern_wdata;
    logic                           img_we;
    logic [c2dt_pkg::IMG_AW-1:0]    img_waddr;
    logic [c2dt_pkg::PIXEL_BITS-1:0] img_wdata;

    assign kern_we = in_fire && is_kload &&
                     (int'(in_data.row) < c2dt_pkg::KSIDE) &&
                     (int'(in_data.col) < c2dt_pkg::KSIDE);
    assign kern_waddr = c2dt_pkg::KAW'(in_data.row) +
                        c2dt_pkg::KAW'(in_data.col) * c2dt_pkg::KAW'(c2dt_pkg::KSIDE);
    assign kern_wdata = c2dt_pkg::COEF_BITS'(in_data.value);

    assign img_we    = in_fire && is_iload && !outside;
    assign img_waddr = {c2dt_pkg::IDX_W'(in_data.col), c2dt_pkg::IDX_W'(in_data.row)};
    assign img_wdata = c2dt_pkg::PIXEL_BITS'(in_data.value);

    // Request context captured at acceptance.
    c2dt_pkg::state_t             state_reg;
    c2dt_pkg::state_t             state_next;
    logic [c2dt_pkg::IDX_W-1:0]   row_reg;
    logic [c2dt_pkg::IDX_W-1:0]   col_reg;
    logic [c2dt_pkg::SIZE_W-1:0]  nr_reg;
    logic [c2dt_pkg::SIZE_W-1:0]  nc_reg;
    logic [c2dt_pkg::RAD_W-1:0]   rad_reg;
    logic [c2dt_pkg::KIDX_W-1:0]  last_reg;
    logic [c2dt_pkg::KIDX_W-1:0]  dr_idx_reg;
    logic [c2dt_pkg::KIDX_W-1:0]  dc_idx_reg;
    logic                         bad_reg;

    // Pipeline: tap issue, RAM read, product, accumulate.
    logic                                tap_vld_reg;
    logic                                prod_vld_reg;
    logic signed [c2dt_pkg::PROD_W-1:0]  prod_reg;
    logic signed [c2dt_pkg::RESP_W-1:0]  acc_reg;
    logic                                out_valid_reg;
    c2dt_pkg::out_item_t                 out_data_reg;

    // Control decoded from the state.
    logic issue;
    logic out_load;
    logic last_tap;
    logic pipe_empty;

    assign last_tap   = (dr_idx_reg == last_reg) && (dc_idx_reg == last_reg);
    assign pipe_empty = !tap_vld_reg && !prod_vld_reg;

    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            c2dt_pkg::ST_IDLE:  in_stall = 1'b0;
            c2dt_pkg::ST_RUN:   issue    = 1'b1;
            c2dt_pkg::ST_FLUSH: ;
            c2dt_pkg::ST_DONE:  out_load = !out_valid_reg || !out_stall;
            default:            ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c2dt_pkg::ST_IDLE:
            begin
                if (in_fire && is_compute)
                begin
                    state_next = (size_bad || outside) ? c2dt_pkg::ST_DONE : c2dt_pkg::ST_RUN;
                end
            end
            c2dt_pkg::ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = c2dt_pkg::ST_FLUSH;
                end
            end
            c2dt_pkg::ST_FLUSH:
            begin
                if (pipe_empty)
                begin
                    state_next = c2dt_pkg::ST_DONE;
                end
            end
            c2dt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = c2dt_pkg::ST_IDLE;
                end
            end
            default: state_next = c2dt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= c2dt_pkg::ST_IDLE;
            dr_idx_reg    <= '0;
            dc_idx_reg    <= '0;
            tap_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_vld_reg  <= issue;
            prod_vld_reg <= tap_vld_reg;
            if (in_fire && is_compute)
            begin
                dr_idx_reg <= '0;
                dc_idx_reg <= '0;
            end
            else if (issue)
            begin
                // Rows run fastest, matching the column-major image layout.
                if (dr_idx_reg == last_reg)
                begin
                    dr_idx_reg <= '0;
                    dc_idx_reg <= dc_idx_reg + 1'b1;
                end
                else
                begin
                    dr_idx_reg <= dr_idx_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire && is_compute)
        begin
            row_reg  <= c2dt_pkg::IDX_W'(in_data.row);
            col_reg  <= c2dt_pkg::IDX_W'(in_data.col);
            nr_reg   <= nr_c;
            nc_reg   <= nc_c;
            rad_reg  <= rad_c;
            last_reg <= c2dt_pkg::KIDX_W'({rad_c, 1'b0});
            bad_reg  <= size_bad;
        end
        if (in_fire && is_compute)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + c2dt_pkg::RESP_W'(prod_reg);
        end
        if (out_load)
        begin
            out_data_reg.response <= acc_reg;
            out_data_reg.bad_size <= bad_reg;
        end
    end

    // Tap address generation with half-sample reflection. A crossed edge
    // mirrors the kernel index in that dimension.
    logic signed [c2dt_pkg::POS_W-1:0] pos_r;
    logic signed [c2dt_pkg::POS_W-1:0] pos_c;
    logic signed [c2dt_pkg::POS_W-1:0] nr_s;
    logic signed [c2dt_pkg::POS_W-1:0] nc_s;
    logic [c2dt_pkg::IDX_W-1:0]        rr;
    logic [c2dt_pkg::IDX_W-1:0]        cc;
    logic [c2dt_pkg::KIDX_W-1:0]       kr;
    logic [c2dt_pkg::KIDX_W-1:0]       kc;

    always_comb
    begin
        nr_s  = c2dt_pkg::POS_W'(nr_reg);
        nc_s  = c2dt_pkg::POS_W'(nc_reg);
        pos_r = c2dt_pkg::POS_W'(row_reg) + c2dt_pkg::POS_W'(dr_idx_reg)
                - c2dt_pkg::POS_W'(rad_reg);
        pos_c = c2dt_pkg::POS_W'(col_reg) + c2dt_pkg::POS_W'(dc_idx_reg)
                - c2dt_pkg::POS_W'(rad_reg);
        if (pos_r < 0)
        begin
            rr = c2dt_pkg::IDX_W'(~pos_r);
            kr = dr_idx_reg;
        end
        else if (pos_r >= nr_s)
        begin
            rr = c2dt_pkg::IDX_W'(nr_s + nr_s - c2dt_pkg::POS_W'(1) - pos_r);
            kr = dr_idx_reg;
        end
        else
        begin
            rr = c2dt_pkg::IDX_W'(pos_r);
            kr = last_reg - dr_idx_reg;
        end
        if (pos_c < 0)
        begin
            cc = c2dt_pkg::IDX_W'(~pos_c);
            kc = dc_idx_reg;
        end
        else if (pos_c >= nc_s)
        begin
            cc = c2dt_pkg::IDX_W'(nc_s + nc_s - c2dt_pkg::POS_W'(1) - pos_c);
            kc = dc_idx_reg;
        end
        else
        begin
            cc = c2dt_pkg::IDX_W'(pos_c);
            kc = last_reg - dc_idx_reg;
        end
    end

    logic [c2dt_pkg::IMG_AW-1:0]     img_raddr;
    logic [c2dt_pkg::KAW-1:0]        kern_raddr;
    logic [c2dt_pkg::PIXEL_BITS-1:0] img_rdata;
    logic [c2dt_pkg::COEF_BITS-1:0]  kern_rdata;

    assign img_raddr  = {cc, rr};
    assign kern_raddr = c2dt_pkg::KAW'(kr) + c2dt_pkg::KAW'(kc) * c2dt_pkg::KAW'(c2dt_pkg::KSIDE);

    c2dt_ram #(
        .WIDTH (c2dt_pkg::PIXEL_BITS),
        .DEPTH (c2dt_pkg::IMG_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    c2dt_ram #(
        .WIDTH (c2dt_pkg::COEF_BITS),
        .DEPTH (c2dt_pkg::KDEPTH)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (kern_we),
        .waddr (kern_waddr),
        .wdata (kern_wdata),
        .raddr (kern_raddr),
        .rdata (kern_rdata)
    );

    // One signed multiply per tap, registered before accumulation.
    always_ff @(posedge clk)
    begin
        if (tap_vld_reg)
        begin
            prod_reg <= $signed(img_rdata) * $signed(kern_rdata);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/c2dt_checker.sv =====
// ============================================================================
// c2dt_checker
// Port-level checks of the transposed convolution unit, bound to the top.
// ============================================================================
`include "assert_macros.svh"

module c2dt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input c2dt_pkg::in_item_t          in_data,
    input logic                        out_valid,
    input logic                        out_stall,
    input c2dt_pkg::out_item_t         out_data
);

    logic in_fire;
    logic fire_compute;
    logic fire_other;

    assign in_fire      = in_valid && !in_stall;
    assign fire_compute = in_fire && (in_data.func == c2dt_pkg::FUNC_COMPUTE);
    assign fire_other   = in_fire && (in_data.func != c2dt_pkg::FUNC_COMPUTE);

    // A stalled result stays put.
    `C2DT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // An undersized image always answers zero.
    `C2DT_ASSERT_NOW(a_bad_is_zero, out_valid && out_data.bad_size, out_data.response == '0)
    // Loads and unused codes never make the unit busy.
    `C2DT_ASSERT_NEXT(a_load_no_busy, fire_other, !in_stall)
    // A compute request holds off the next transaction.
    `C2DT_ASSERT_NEXT(a_compute_busy, fire_compute, in_stall)

endmodule

bind conv2d_transpose_symmetric_border_unit c2dt_checker u_c2dt_checker (.*);
